### rtl/core/fpda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpda_pkg
// Shared types, constants and helpers for the fixed-point decimal formatter.
// ----------------------------------------------------------------------------
package fpda_pkg;

    localparam int VALUE_W    = 31;
    localparam int MAG_W      = 30;
    localparam int NUM_DIGITS = 9;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 7;

    localparam logic [MAG_W-1:0] MAG_LIMIT = 30'd999999999;

    // Binary to BCD conversion: three shift-add-3 steps a cycle
    localparam int BITS_PER_STEP = 3;
    localparam int STEPS         = MAG_W / BITS_PER_STEP;
    localparam int CNT_W         = $clog2(STEPS + 1);

    // Digit positions, 0 is the least significant digit
    localparam int POS_W = $clog2(NUM_DIGITS);
    localparam logic [POS_W-1:0] INT_LOW_SHORT = POS_W'(3);
    localparam logic [POS_W-1:0] INT_LOW_LONG  = POS_W'(6);

    // ASCII codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] t_bcd;

    typedef struct packed {
        logic neg;
        logic frac_mode;
        t_bcd digits;
    } t_num;

    typedef enum logic [1:0] {
        PH_SIGN,
        PH_INT,
        PH_POINT,
        PH_FRAC
    } t_phase;

    // Add three to every BCD digit of five or more
    function automatic t_bcd bcd_adjust(input t_bcd bcd);
        t_bcd res;
        res = bcd;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd[i] >= DIGIT_W'(5)) begin
                res[i] = bcd[i] + DIGIT_W'(3);
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### rtl/core/fpda_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpda_front
// Takes a number, saturates its magnitude and converts it to nine BCD digits.
// ----------------------------------------------------------------------------
module fpda_front
    import fpda_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_push,
    output logic                           o_full,
    input  wire logic signed [VALUE_W-1:0] i_value,
    input  wire logic                      i_frac_mode,
    output logic                           o_q_push,
    output t_num                           o_q_data,
    input  wire logic                      i_q_full
);

    logic             r_busy, n_busy;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [MAG_W-1:0] r_bin, n_bin;
    t_bcd             r_bcd, n_bcd;
    logic             r_neg, n_neg;
    logic             r_mode, n_mode;

    logic             accept;
    logic             done;
    logic [VALUE_W-1:0] mag_full;
    logic [MAG_W-1:0] mag_sat;
    t_bcd             bcd_t;
    logic [MAG_W-1:0] bin_t;

    assign done     = r_busy && (r_cnt == CNT_W'(STEPS));
    assign o_q_push = done && !i_q_full;
    assign o_full   = r_busy && !o_q_push;
    assign accept   = i_push && !o_full;
    assign o_q_data = '{neg: r_neg, frac_mode: r_mode, digits: r_bcd};

    // Magnitude of the two's complement input, clipped to nine digits
    always_comb begin
        mag_full = i_value[VALUE_W-1] ? (~unsigned'(i_value) + VALUE_W'(1))
                                      : unsigned'(i_value);
        mag_sat  = (mag_full > VALUE_W'(MAG_LIMIT)) ? MAG_LIMIT : mag_full[MAG_W-1:0];
    end

    always_comb begin
        bcd_t = r_bcd;
        bin_t = r_bin;
        for (int s = 0; s < BITS_PER_STEP; s++) begin
            bcd_t = bcd_adjust(bcd_t);
            {bcd_t, bin_t} = {bcd_t, bin_t} << 1;
        end

        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_neg  = r_neg;
        n_mode = r_mode;

        if (r_busy && !done) begin
            n_bcd = bcd_t;
            n_bin = bin_t;
            n_cnt = r_cnt + CNT_W'(1);
        end
        if (o_q_push) begin
            n_busy = 1'b0;
        end
        if (accept) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_bin  = mag_sat;
            n_bcd  = '0;
            n_neg  = i_value[VALUE_W-1];
            n_mode = i_frac_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_neg  <= n_neg;
        r_mode <= n_mode;
    end

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_busy && r_cnt == '0))
        else $error("front did not restart conversion after accept");
`endif

endmodule
`default_nettype wire

### rtl/core/fpda_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpda_queue
// Short queue of converted numbers between the front and the back.
// ----------------------------------------------------------------------------
module fpda_queue
    import fpda_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  wire t_num i_wr_data,
    output logic      o_full,
    input  wire logic i_rd,
    output t_num      o_rd_data,
    output logic      o_empty
);

    t_num              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_count;

    assign o_full    = (r_count == QCNT_W'(QDEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (i_rd) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_rd && !i_wr) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && o_full))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rd && o_empty))
        else $error("queue read while empty");
`endif

endmodule
`default_nettype wire

### rtl/core/fpda_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpda_back
// Walks one converted number and emits its text one character at a time.
// ----------------------------------------------------------------------------
module fpda_back
    import fpda_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_empty,
    input  wire t_num               i_q_data,
    output logic                    o_q_pop,
    output logic                    o_empty,
    input  wire logic               i_pop,
    output logic [CHAR_W-1:0]       o_character,
    output logic                    o_last
);

    t_phase           r_phase, n_phase;
    logic             r_act, n_act;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_end, n_end;
    logic [POS_W-1:0] r_int_low, n_int_low;
    logic             r_has_frac, n_has_frac;
    t_bcd             r_digits, n_digits;

    logic [POS_W-1:0] ld_int_low, ld_start, ld_end;
    logic             ld_has_frac;
    logic             need_load;
    logic [CHAR_W-1:0] digit_char;

    // Classify the number at the queue head
    always_comb begin
        ld_int_low  = i_q_data.frac_mode ? INT_LOW_LONG : INT_LOW_SHORT;
        ld_start    = ld_int_low;
        ld_end      = '0;
        ld_has_frac = 1'b0;
        for (int p = 0; p < NUM_DIGITS; p++) begin
            if (POS_W'(p) > ld_int_low && i_q_data.digits[p] != '0) begin
                ld_start = POS_W'(p);
            end
        end
        for (int p = NUM_DIGITS - 1; p >= 0; p--) begin
            if (POS_W'(p) < ld_int_low && i_q_data.digits[p] != '0) begin
                ld_end      = POS_W'(p);
                ld_has_frac = 1'b1;
            end
        end
    end

    assign digit_char = CH_ZERO + CHAR_W'(r_digits[r_pos]);
    assign o_empty    = !r_act;

    always_comb begin
        n_phase    = r_phase;
        n_act      = r_act;
        n_pos      = r_pos;
        n_end      = r_end;
        n_int_low  = r_int_low;
        n_has_frac = r_has_frac;
        n_digits   = r_digits;
        o_q_pop    = 1'b0;

        case (r_phase)
            PH_SIGN: begin
                o_character = CH_MINUS;
                o_last      = 1'b0;
            end
            PH_INT: begin
                o_character = digit_char;
                o_last      = (r_pos == r_int_low) && !r_has_frac;
            end
            PH_POINT: begin
                o_character = CH_POINT;
                o_last      = 1'b0;
            end
            PH_FRAC: begin
                o_character = digit_char;
                o_last      = (r_pos == r_end);
            end
            default: begin
                o_character = CH_ZERO;
                o_last      = 1'b0;
            end
        endcase

        // Advance through the text on each pop
        if (r_act && i_pop) begin
            case (r_phase)
                PH_SIGN: n_phase = PH_INT;
                PH_INT: begin
                    if (r_pos == r_int_low) begin
                        n_phase = PH_POINT;
                    end else begin
                        n_pos = r_pos - POS_W'(1);
                    end
                end
                PH_POINT: begin
                    n_phase = PH_FRAC;
                    n_pos   = r_int_low - POS_W'(1);
                end
                PH_FRAC: n_pos = r_pos - POS_W'(1);
                default: n_phase = PH_INT;
            endcase
        end

        need_load = !r_act || (i_pop && o_last);
        if (need_load) begin
            if (!i_q_empty) begin
                o_q_pop    = 1'b1;
                n_act      = 1'b1;
                n_phase    = i_q_data.neg ? PH_SIGN : PH_INT;
                n_pos      = ld_start;
                n_end      = ld_end;
                n_int_low  = ld_int_low;
                n_has_frac = ld_has_frac;
                n_digits   = i_q_data.digits;
            end else begin
                n_act = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= 1'b0;
            r_phase <= PH_INT;
        end else begin
            r_act   <= n_act;
            r_phase <= n_phase;
        end
        r_pos      <= n_pos;
        r_end      <= n_end;
        r_int_low  <= n_int_low;
        r_has_frac <= n_has_frac;
        r_digits   <= n_digits;
    end

`ifndef ASSERT_OFF
    a_frac_needs_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_act && (r_phase == PH_POINT || r_phase == PH_FRAC)) |-> r_has_frac)
        else $error("fraction emitted for a number without one");
`endif

endmodule
`default_nettype wire

### rtl/core/fixed_point_decimal_to_ascii.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_decimal_to_ascii
// Formats signed scaled decimal numbers as ASCII text, one character a pop.
// ----------------------------------------------------------------------------
// Push a 31-bit two's complement number when full is low; pop characters
// while empty is low. The text is an optional '-', the integer digits without
// leading zeros, then, only if the fraction is nonzero, '.' and the fraction
// without trailing zeros; last marks the final character. frac_mode selects
// three (0) or six (1) implied fractional digits and is sampled when a number
// is pushed. Magnitudes above 999999999 clip to 999999999, sign kept. The
// front loads each number and then converts it from binary to BCD at three
// bits a cycle, and a new number may be pushed in the cycle its predecessor
// moves into the two-entry queue. While pop is held high the back emits one
// character a cycle, from 1 to 11 per number, with no gap between numbers
// when the next number is already queued.
// ----------------------------------------------------------------------------
module fixed_point_decimal_to_ascii
    import fpda_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // number input, queue style
    input  wire logic                      push,
    output logic                           full,
    input  wire logic signed [VALUE_W-1:0] i_value,
    // character output, queue style
    output logic                           empty,
    input  wire logic                      pop,
    output logic [CHAR_W-1:0]              o_character,
    output logic                           o_last,
    // frac_mode register write
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic                      i_cfg_data
);

    logic r_frac_mode;
    logic q_wr, q_full, q_rd, q_empty;
    t_num q_wr_data, q_rd_data;

    // Always take a register write transaction
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_frac_mode <= i_cfg_data;
        end
    end

    // Front: accept, clip and convert to BCD
    fpda_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_value     (i_value),
        .i_frac_mode (r_frac_mode),
        .o_q_push    (q_wr),
        .o_q_data    (q_wr_data),
        .i_q_full    (q_full)
    );

    // Decouple conversion from character output
    fpda_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_data (q_wr_data),
        .o_full    (q_full),
        .i_rd      (q_rd),
        .o_rd_data (q_rd_data),
        .o_empty   (q_empty)
    );

    // Back: walk the digits and emit characters
    fpda_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_data    (q_rd_data),
        .o_q_pop     (q_rd),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule
`default_nettype wire
